// ----- hw/rtl/edfs_pkg.sv -----
// ----------------------------------------------------------------------------
// edfs_pkg
// Shared widths, codes and control/status bundles of the EDF tick scheduler.
// ----------------------------------------------------------------------------
package edfs_pkg;

  localparam int TIME_W     = 32;  // current time, run length
  localparam int STAMP_W    = 33;  // next release, absolute deadline
  localparam int WORK_W     = 16;  // capacity, period, relative deadline
  localparam int SLOT_W     = 4;   // task index on the ports
  localparam int NUM_W      = 5;   // num_tasks register
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // input item kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_TASKS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_LENGTH = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;    // write task slot from the input beat
    logic rel;     // release pass over all lanes
    logic commit;  // run the picked task, register the result
    logic fin;     // with commit: tick past run length
  } edfs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic past_end;  // current time >= run length
    logic out_free;  // output register can take a result this cycle
  } edfs_sts_t;

endpackage

// ----- hw/rtl/edfs_ctrl.sv -----
// ----------------------------------------------------------------------------
// edfs_ctrl
// Sequencer: accept, release pass, min-tree settle, commit.
// ----------------------------------------------------------------------------
module edfs_ctrl
  import edfs_pkg::*;
#(
  parameter int TREE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      in_kind,
  input  edfs_sts_t sts,
  output edfs_cmd_t cmd
);

  localparam int CNT_W = $clog2(TREE_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_REL  = 2'd1;
  localparam logic [1:0] S_TREE = 2'd2;
  localparam logic [1:0] S_PICK = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             fin_r, fin_nxt;
  logic             accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    fin_nxt    = fin_r;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            state_nxt = S_REL;
          end
        end
      end
      S_REL: begin
        if (sts.past_end) begin
          fin_nxt   = 1'b1;
          state_nxt = S_PICK;
        end else begin
          cmd.rel   = 1'b1;
          cnt_nxt   = CNT_W'(TREE_DEPTH - 1);
          state_nxt = S_TREE;
        end
      end
      S_TREE: begin
        if (cnt_r == '0) begin
          state_nxt = S_PICK;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_PICK: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          cmd.fin    = fin_r;
          fin_nxt    = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

// ----- hw/rtl/edfs_datapath.sv -----
// ----------------------------------------------------------------------------
// edfs_datapath
// Task lanes, registered minimum tree, time and config registers, result reg.
// ----------------------------------------------------------------------------
module edfs_datapath
  import edfs_pkg::*;
#(
  parameter int MAX_TASKS  = 16,
  parameter int TREE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [SLOT_W-1:0]     in_task_index,
  input  logic [WORK_W-1:0]     in_capacity,
  input  logic [WORK_W-1:0]     in_period,
  input  logic [WORK_W-1:0]     in_deadline,
  input  edfs_cmd_t             cmd,
  output edfs_sts_t             sts,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TIME_W-1:0]     out_tick_time,
  output logic [SLOT_W-1:0]     out_running_task,
  output logic                  out_idle,
  output logic                  out_finished
);

  localparam int LEAVES = 1 << TREE_DEPTH;
  localparam int NODES  = LEAVES - 1;

  typedef struct packed {
    logic                  vld;
    logic [STAMP_W-1:0]    dl;
    logic [TREE_DEPTH-1:0] idx;
  } node_t;

  // left operand holds the lower indices, so it wins ties
  function automatic node_t pick_min(input node_t a, input node_t b);
    node_t r;
    if (a.vld && (!b.vld || (a.dl <= b.dl))) r = a;
    else                                      r = b;
    return r;
  endfunction

  logic [NUM_W-1:0]  num_tasks_r;
  logic [TIME_W-1:0] run_length_r;
  logic [TIME_W-1:0] time_r;

  logic [WORK_W-1:0]  cap_r   [MAX_TASKS];
  logic [WORK_W-1:0]  per_r   [MAX_TASKS];
  logic [WORK_W-1:0]  rdl_r   [MAX_TASKS];
  logic [WORK_W-1:0]  rem_r   [MAX_TASKS];
  logic [STAMP_W-1:0] nrel_r  [MAX_TASKS];
  logic [STAMP_W-1:0] adl_r   [MAX_TASKS];

  node_t leaf     [LEAVES];
  node_t node_r   [NODES];
  node_t node_nxt [NODES];
  node_t root;

  logic              out_valid_r;
  logic [TIME_W-1:0] out_time_r;
  logic [SLOT_W-1:0] out_task_r;
  logic              out_idle_r;
  logic              out_fin_r;
  logic              run_ok;

  assign root   = node_r[0];
  assign run_ok = cmd.commit && !cmd.fin && root.vld;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_tasks_r  <= NUM_W'(1);
      run_length_r <= TIME_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_TASKS:  num_tasks_r  <= cfg_wdata[NUM_W-1:0];
        REG_RUN_LENGTH: run_length_r <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
    end else if (run_ok || (cmd.commit && !cmd.fin)) begin
      time_r <= time_r + 1'b1;
    end
  end

  // task lanes
  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_lane
    logic act, rel_hit, run_hit, ld_hit;

    assign act     = (32'(num_tasks_r) > i);
    assign rel_hit = cmd.rel && act && (nrel_r[i] == {1'b0, time_r});
    assign run_hit = run_ok && (root.idx == TREE_DEPTH'(i));
    assign ld_hit  = cmd.load && (32'(in_task_index) == i);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cap_r[i]  <= '0;
        per_r[i]  <= '0;
        rdl_r[i]  <= '0;
        rem_r[i]  <= '0;
        nrel_r[i] <= '0;
        adl_r[i]  <= '0;
      end else if (ld_hit) begin
        cap_r[i]  <= in_capacity;
        per_r[i]  <= in_period;
        rdl_r[i]  <= in_deadline;
        rem_r[i]  <= '0;
        nrel_r[i] <= '0;
        adl_r[i]  <= '0;
      end else if (rel_hit) begin
        rem_r[i]  <= cap_r[i];
        adl_r[i]  <= {1'b0, time_r} + STAMP_W'(rdl_r[i]);
        nrel_r[i] <= nrel_r[i] + STAMP_W'(per_r[i]);
      end else if (run_hit) begin
        rem_r[i]  <= rem_r[i] - 1'b1;
      end
    end

    assign leaf[i].vld = act && (rem_r[i] != '0);
    assign leaf[i].dl  = adl_r[i];
    assign leaf[i].idx = TREE_DEPTH'(i);
  end

  for (genvar j = MAX_TASKS; j < LEAVES; j++) begin : g_pad
    assign leaf[j] = '0;
  end

  // min tree, one level per cycle
  for (genvar k = 0; k < NODES; k++) begin : g_node
    node_t lhs, rhs;
    if (2 * k + 1 < NODES) begin : g_int
      assign lhs = node_r[2 * k + 1];
      assign rhs = node_r[2 * k + 2];
    end else begin : g_leaf
      assign lhs = leaf[2 * k + 1 - NODES];
      assign rhs = leaf[2 * k + 2 - NODES];
    end
    assign node_nxt[k] = pick_min(lhs, rhs);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NODES; k++) begin
      node_r[k] <= node_nxt[k];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_time_r <= time_r;
      out_task_r <= run_ok ? SLOT_W'(root.idx) : '0;
      out_idle_r <= !cmd.fin && !root.vld;
      out_fin_r  <= cmd.fin;
    end
  end

  assign sts.past_end = (time_r >= run_length_r);
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_tick_time    = out_time_r;
  assign out_running_task = out_task_r;
  assign out_idle         = out_idle_r;
  assign out_finished     = out_fin_r;

endmodule

// ----- hw/rtl/edf_tick_scheduler.sv -----
// Load beat: written on the accepting edge, gives no result, no stall after it.
// Tick beat: release pass, tree settle, then pick, which registers the result;
//   in_stall held till then. Tree depth clog2(MAX_TASKS), at least 1 (4 at 16 slots).
// Tick at or past run length: straight to pick, result flagged finished.
// Reset (rst_n, synchronous): tables and time cleared at once, num_tasks = 1,
//   run_length = 1; no clearing pass.
// ----------------------------------------------------------------------------
// edf_tick_scheduler
// Earliest-deadline-first periodic scheduler: one result beat per tick.
// ----------------------------------------------------------------------------
module edf_tick_scheduler
  import edfs_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input beats
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic [SLOT_W-1:0]     in_task_index,
  input  logic [WORK_W-1:0]     in_capacity,
  input  logic [WORK_W-1:0]     in_period,
  input  logic [WORK_W-1:0]     in_deadline,
  // result beats
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TIME_W-1:0]     out_tick_time,
  output logic [SLOT_W-1:0]     out_running_task,
  output logic                  out_idle,
  output logic                  out_finished
);

  // tree over a power-of-two leaf row, at least two leaves
  localparam int TREE_DEPTH = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  edfs_cmd_t cmd;
  edfs_sts_t sts;

  // Sequencer. Loads are written on the accepting edge. A tick walks
  // release -> tree settle -> pick, or to pick at or past run length;
  // the pick waits while the result register is still held by a stalled beat, so results never overwrite.
  edfs_ctrl #(
    .TREE_DEPTH (TREE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_kind  (in_kind),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Lanes release in parallel; the registered tree finds the earliest
  // absolute deadline, lower index on a tie.
  edfs_datapath #(
    .MAX_TASKS  (MAX_TASKS),
    .TREE_DEPTH (TREE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_task_index    (in_task_index),
    .in_capacity      (in_capacity),
    .in_period        (in_period),
    .in_deadline      (in_deadline),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tick_time    (out_tick_time),
    .out_running_task (out_running_task),
    .out_idle         (out_idle),
    .out_finished     (out_finished)
  );

  // a commit never lands on a held result beat
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid || !out_stall))
    else $error("result overwritten while stalled");

  // every commit shows up as a result beat
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("commit without result beat");

  // idle and finished beats carry task 0 and never both flags
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_idle || out_finished) |->
      (out_running_task == '0) && !(out_idle && out_finished))
    else $error("inconsistent result flags");

  // loads are taken only on an accepted beat
  a_load_acc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (in_valid && !in_stall && (in_kind == KIND_LOAD)))
    else $error("load without accepted load beat");

endmodule
